// ----- rtl/btpg_pkg.sv -----
// Package for the beveled tile pixel generator.
// Holds the shared widths, register indexes, the configuration and pixel work
// structs, and the bevel color function. Depends on nothing.
`default_nettype none

package btpg_pkg;

    localparam int COORD_BITS = 12;
    localparam int SCR_W      = 12;
    localparam int CELL_W     = 8;
    localparam int PB_W       = 3;
    localparam int COLOR_W    = 24;
    localparam int ORG_W      = 16;
    localparam int XY_W       = ORG_W + 1;
    localparam int PROD_W     = XY_W + COORD_BITS;
    localparam int OFF_W      = XY_W + 2;
    localparam int IDX_W      = PROD_W + 2;
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int MUL_W      = AREA_W + PB_W;
    localparam int ADDR_W     = 26;
    localparam int PADDR_W    = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CELL_W-1:0] BEVEL_BAND  = 8'd3;
    localparam logic [7:0]        BEVEL_DELTA = 8'd100;
    localparam logic [7:0]        CHAN_MAX    = 8'd255;
    localparam logic [7:0]        LIGHT_LIMIT = CHAN_MAX - BEVEL_DELTA;

    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LANDSCAPE     = 3'd2;
    localparam logic [2:0] REG_CELL_WIDTH    = 3'd3;
    localparam logic [2:0] REG_CELL_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_PIXEL_BYTES   = 3'd5;
    localparam logic [2:0] REG_RGB_ORDER     = 3'd6;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [SCR_W-1:0]  screen_width;
        logic [SCR_W-1:0]  screen_height;
        logic              landscape_mode;
        logic [CELL_W-1:0] cell_width;
        logic [CELL_W-1:0] cell_height;
        logic [PB_W-1:0]   pixel_bytes;
        logic              rgb_order;
    } cfg_t;

    typedef struct packed {
        logic [XY_W-1:0]    x;
        logic [XY_W-1:0]    y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } px_work_t;

    function automatic logic [COLOR_W-1:0] bevel_color(
        input logic [COLOR_W-1:0] color,
        input logic               light
    );
        logic [COLOR_W-1:0] res;
        logic [7:0]         c;
        res = '0;
        for (int s = 0; s < 3; s++) begin
            c = color[8*s +: 8];
            if (light) begin
                res[8*s +: 8] = (c > LIGHT_LIMIT) ? CHAN_MAX : c + BEVEL_DELTA;
            end
            else begin
                res[8*s +: 8] = (c < BEVEL_DELTA) ? 8'd0 : c - BEVEL_DELTA;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/beveled_tile_pixel_generator_top.sv -----
// Beveled tile pixel generator: one pixel result per tick item during a cell walk,
// one item per cycle while item_stall is low. An accepted tick passes the queue,
// index product, add and screen check, byte address product into the output register.
// Input stall rises only when the four-entry pixel queue is full.
// Reset clears the walk state, the queue and the pipeline valids; the
// configuration registers return to their documented defaults.
`default_nettype none

module beveled_tile_pixel_generator_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [btpg_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [31:0]                          pwdata,
    output      logic [31:0]                          prdata,
    output      logic                                 pready,
    input  wire logic                                 item_valid,
    output      logic                                 item_stall,
    input  wire logic                                 op,
    input  wire logic signed [8:0]                    cell_col,
    input  wire logic signed [8:0]                    cell_row,
    input  wire logic [btpg_pkg::COLOR_W-1:0]         fill_color,
    output      logic                                 result_valid,
    input  wire logic                                 result_stall,
    output      logic                                 write_enable,
    output      logic [btpg_pkg::ADDR_W-1:0]          byte_address,
    output      logic [7:0]                           first_byte,
    output      logic [7:0]                           middle_byte,
    output      logic [7:0]                           third_byte,
    output      logic                                 last_pixel
);
    import btpg_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       accept, push, pop, fifo_full, fifo_empty;
    px_work_t   push_data, head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_SCREEN_WIDTH:  cfg_next.screen_width   = pwdata[SCR_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height  = pwdata[SCR_W-1:0];
                REG_LANDSCAPE:     cfg_next.landscape_mode = pwdata[0];
                REG_CELL_WIDTH:    cfg_next.cell_width     = pwdata[CELL_W-1:0];
                REG_CELL_HEIGHT:   cfg_next.cell_height    = pwdata[CELL_W-1:0];
                REG_PIXEL_BYTES:   cfg_next.pixel_bytes    = pwdata[PB_W-1:0];
                REG_RGB_ORDER:     cfg_next.rgb_order      = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = 32'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(cfg_reg.screen_height);
            REG_LANDSCAPE:     prdata = 32'(cfg_reg.landscape_mode);
            REG_CELL_WIDTH:    prdata = 32'(cfg_reg.cell_width);
            REG_CELL_HEIGHT:   prdata = 32'(cfg_reg.cell_height);
            REG_PIXEL_BYTES:   prdata = 32'(cfg_reg.pixel_bytes);
            REG_RGB_ORDER:     prdata = 32'(cfg_reg.rgb_order);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.screen_width   <= 12'd1080;
            cfg_reg.screen_height  <= 12'd1920;
            cfg_reg.landscape_mode <= 1'b0;
            cfg_reg.cell_width     <= 8'd54;
            cfg_reg.cell_height    <= 8'd96;
            cfg_reg.pixel_bytes    <= 3'd3;
            cfg_reg.rgb_order      <= 1'b0;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    assign item_stall = fifo_full;
    assign accept     = item_valid && !item_stall;

    btpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .op         (op),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .fill_color (fill_color),
        .push       (push),
        .push_data  (push_data)
    );

    btpg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .head      (head)
    );

    btpg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fifo_empty   (fifo_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .write_enable (write_enable),
        .byte_address (byte_address),
        .first_byte   (first_byte),
        .middle_byte  (middle_byte),
        .third_byte   (third_byte),
        .last_pixel   (last_pixel)
    );

endmodule

`default_nettype wire

// ----- rtl/btpg_front.sv -----
// Front end of the beveled tile pixel generator.
// Accepts start and tick items, keeps the cell walk state and classifies each
// pixel's color; uses btpg_pkg.
`default_nettype none

module btpg_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire btpg_pkg::cfg_t                 cfg,
    input  wire logic                           accept,
    input  wire logic                           op,
    input  wire logic signed [8:0]              cell_col,
    input  wire logic signed [8:0]              cell_row,
    input  wire logic [btpg_pkg::COLOR_W-1:0]   fill_color,
    output      logic                           push,
    output      btpg_pkg::px_work_t             push_data
);
    import btpg_pkg::*;

    logic                active_reg, active_next;
    logic [CELL_W-1:0]   u_reg, u_next;
    logic [CELL_W-1:0]   v_reg, v_next;
    logic [ORG_W-1:0]    ox_reg, ox_next;
    logic [ORG_W-1:0]    oy_reg, oy_next;
    logic [COLOR_W-1:0]  base_reg, base_next;
    logic [COLOR_W-1:0]  light_reg, light_next;
    logic [COLOR_W-1:0]  dark_reg, dark_next;

    logic [CELL_W:0] cw9, ch9, u1, v1, u3, v3;
    logic            start_ok, tick_ok;
    logic            inner, is_light, is_dark, border, row_end, cell_end;
    logic [COLOR_W-1:0] pix_color;

    assign cw9 = {1'b0, cfg.cell_width};
    assign ch9 = {1'b0, cfg.cell_height};
    assign u1  = {1'b0, u_reg} + 9'd1;
    assign v1  = {1'b0, v_reg} + 9'd1;
    assign u3  = {1'b0, u_reg} + {1'b0, BEVEL_BAND};
    assign v3  = {1'b0, v_reg} + {1'b0, BEVEL_BAND};

    assign start_ok = accept && (op == OP_START) && !cell_col[8] && !cell_row[8]
                      && (cfg.cell_width != '0) && (cfg.cell_height != '0);
    assign tick_ok  = accept && (op == OP_TICK) && active_reg;

    assign inner    = (u_reg != '0) && (u1 < cw9) && (v_reg != '0) && (v1 < ch9);
    assign is_light = inner && ((v_reg < BEVEL_BAND) || (u3 >= cw9));
    assign is_dark  = inner && ((v3 >= ch9) || (u_reg < BEVEL_BAND));
    assign border   = (u_reg == '0) || (u1 == cw9) || (v_reg == '0) || (v1 == ch9);
    assign row_end  = (u1 >= cw9);
    assign cell_end = row_end && (v1 >= ch9);

    always_comb
    begin
        if (is_light) begin
            pix_color = light_reg;
        end
        else if (is_dark) begin
            pix_color = dark_reg;
        end
        else if (border) begin
            pix_color = '0;
        end
        else begin
            pix_color = base_reg;
        end
    end

    assign push            = tick_ok;
    assign push_data.x     = {1'b0, ox_reg} + {{(XY_W-CELL_W){1'b0}}, u_reg};
    assign push_data.y     = {1'b0, oy_reg} + {{(XY_W-CELL_W){1'b0}}, v_reg};
    assign push_data.color = pix_color;
    assign push_data.last  = cell_end;

    always_comb
    begin
        active_next = active_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        base_next   = base_reg;
        light_next  = light_reg;
        dark_next   = dark_reg;
        if (start_ok) begin
            ox_next     = {8'd0, cell_col[7:0]} * {8'd0, cfg.cell_width};
            oy_next     = {8'd0, cell_row[7:0]} * {8'd0, cfg.cell_height};
            base_next   = fill_color;
            light_next  = bevel_color(fill_color, 1'b1);
            dark_next   = bevel_color(fill_color, 1'b0);
            u_next      = '0;
            v_next      = '0;
            active_next = 1'b1;
        end
        else if (tick_ok) begin
            if (row_end) begin
                u_next = '0;
                if (cell_end) begin
                    v_next      = '0;
                    active_next = 1'b0;
                end
                else begin
                    v_next = v1[CELL_W-1:0];
                end
            end
            else begin
                u_next = u1[CELL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            u_reg      <= '0;
            v_reg      <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            base_reg   <= '0;
            light_reg  <= '0;
            dark_reg   <= '0;
        end
        else begin
            active_reg <= active_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            base_reg   <= base_next;
            light_reg  <= light_next;
            dark_reg   <= dark_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/btpg_fifo.sv -----
// Short pixel work queue between the front end and the back end.
// Holds FIFO_DEPTH entries of btpg_pkg::px_work_t in flip-flops.
`default_nettype none

module btpg_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire btpg_pkg::px_work_t  push_data,
    input  wire logic                pop,
    output      logic                full,
    output      logic                empty,
    output      btpg_pkg::px_work_t  head
);
    import btpg_pkg::*;

    px_work_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_reg, wr_next;
    logic [FIFO_PTR_W-1:0] rd_reg, rd_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign full    = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/btpg_back.sv -----
// Back end of the beveled tile pixel generator.
// Three stages: index product, index add and screen check, byte address
// product with the output register; uses btpg_pkg.
`default_nettype none

module btpg_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire btpg_pkg::cfg_t                cfg,
    input  wire logic                          fifo_empty,
    input  wire btpg_pkg::px_work_t            head,
    output      logic                          pop,
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      logic                          write_enable,
    output      logic [btpg_pkg::ADDR_W-1:0]   byte_address,
    output      logic [7:0]                    first_byte,
    output      logic [7:0]                    middle_byte,
    output      logic [7:0]                    third_byte,
    output      logic                          last_pixel
);
    import btpg_pkg::*;

    logic [COORD_BITS-1:0] sw, sh;
    logic                  advance;

    logic                  s1_valid_reg;
    logic [PROD_W-1:0]     s1_prod_reg, s1_prod_next;
    logic [AREA_W-1:0]     s1_area_reg, s1_area_next;
    logic [OFF_W-1:0]      s1_off_reg, s1_off_next;
    logic [COLOR_W-1:0]    s1_color_reg;
    logic                  s1_last_reg;

    logic                  s2_valid_reg;
    logic                  s2_we_reg, s2_we_next;
    logic [AREA_W-1:0]     s2_idx_reg;
    logic [COLOR_W-1:0]    s2_color_reg;
    logic                  s2_last_reg;
    logic [IDX_W-1:0]      idx;

    logic                  out_valid_reg;
    logic                  we_reg;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [7:0]            first_reg, middle_reg, third_reg;
    logic                  last_reg;
    logic [MUL_W-1:0]      mul;

    assign sw      = cfg.screen_width[COORD_BITS-1:0];
    assign sh      = cfg.screen_height[COORD_BITS-1:0];
    assign advance = !out_valid_reg || !result_stall;
    assign pop     = advance && !fifo_empty;

    always_comb
    begin
        if (cfg.landscape_mode) begin
            s1_prod_next = PROD_W'(head.x) * PROD_W'(sh);
            s1_off_next  = OFF_W'(sh) - OFF_W'(1) - OFF_W'(head.y);
        end
        else begin
            s1_prod_next = PROD_W'(head.y) * PROD_W'(sw);
            s1_off_next  = OFF_W'(head.x);
        end
        s1_area_next = AREA_W'(sw) * AREA_W'(sh);
    end

    assign idx = IDX_W'(s1_prod_reg) + {{(IDX_W-OFF_W){s1_off_reg[OFF_W-1]}}, s1_off_reg};
    assign s2_we_next = !idx[IDX_W-1] && (idx[IDX_W-2:0] < (IDX_W-1)'(s1_area_reg));

    assign mul       = MUL_W'(s2_idx_reg) * MUL_W'(cfg.pixel_bytes);
    assign addr_next = s2_we_reg ? ADDR_W'(mul) : '0;

    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_prod_reg  <= s1_prod_next;
            s1_area_reg  <= s1_area_next;
            s1_off_reg   <= s1_off_next;
            s1_color_reg <= head.color;
            s1_last_reg  <= head.last;
            s2_we_reg    <= s2_we_next;
            s2_idx_reg   <= idx[AREA_W-1:0];
            s2_color_reg <= s1_color_reg;
            s2_last_reg  <= s1_last_reg;
            we_reg       <= s2_we_reg;
            addr_reg     <= addr_next;
            first_reg    <= cfg.rgb_order ? s2_color_reg[23:16] : s2_color_reg[7:0];
            middle_reg   <= s2_color_reg[15:8];
            third_reg    <= cfg.rgb_order ? s2_color_reg[7:0] : s2_color_reg[23:16];
            last_reg     <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            s1_valid_reg  <= !fifo_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign write_enable = we_reg;
    assign byte_address = addr_reg;
    assign first_byte   = first_reg;
    assign middle_byte  = middle_reg;
    assign third_byte   = third_reg;
    assign last_pixel   = last_reg;

endmodule

`default_nettype wire
